### design/dtrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtrd_pkg
// Shared types and constants for the disk track run-length decoder.
// ----------------------------------------------------------------------------
package dtrd_pkg;

  localparam int DATA_W           = 8;
  localparam int REP_W            = 16;
  localparam int PACK_W           = 16;
  localparam int SPT_W            = 7;
  localparam int SECTOR_BYTES_DEF = 512;

  localparam logic [SPT_W-1:0]  SPT_RESET  = 7'd9;
  localparam logic [DATA_W-1:0] RUN_MARKER = 8'hE5;

  typedef enum logic [2:0] {
    PH_HDR_HI  = 3'd0,
    PH_HDR_LO  = 3'd1,
    PH_RAW     = 3'd2,
    PH_DATA    = 3'd3,
    PH_RUN_VAL = 3'd4,
    PH_CNT_HI  = 3'd5,
    PH_CNT_LO  = 3'd6
  } phase_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [REP_W-1:0]  repeat_res;
    logic              track_end;
    logic              error;
  } res_t;

endpackage

### design/dtrd_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtrd_in_reg
// Input byte register; holds one stream byte until the decode stage takes it.
// ----------------------------------------------------------------------------
module dtrd_in_reg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [dtrd_pkg::DATA_W-1:0] data_byte,
  input  logic                       down_busy,
  output logic                       a_valid,
  output logic [dtrd_pkg::DATA_W-1:0] a_byte,
  output logic                       fire
);

  logic accept;
  logic a_valid_next;

  // held byte moves on unless the result register is full and stalled
  assign fire     = a_valid & ~down_busy;
  assign in_stall = a_valid & down_busy;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    if (accept) begin
      a_valid_next = 1'b1;
    end else if (fire) begin
      a_valid_next = 1'b0;
    end else begin
      a_valid_next = a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= a_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_byte <= data_byte;
    end
  end

endmodule

### design/dtrd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtrd_decode
// Track decode state machine: header, raw copy, literals and runs.
// ----------------------------------------------------------------------------
module dtrd_decode #(
  parameter int SECTOR_BYTES = dtrd_pkg::SECTOR_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [dtrd_pkg::SPT_W-1:0]  cfg_wr_data,
  input  logic                        fire,
  input  logic [dtrd_pkg::DATA_W-1:0] a_byte,
  output logic                        res_valid,
  output dtrd_pkg::res_t              res
);

  localparam int SPT_MAX = (1 << dtrd_pkg::SPT_W) - 1;
  localparam int TRACK_W = $clog2(SPT_MAX * SECTOR_BYTES + 1);
  localparam int CMP_W   = (TRACK_W > dtrd_pkg::PACK_W) ? TRACK_W : dtrd_pkg::PACK_W;

  dtrd_pkg::phase_t                phase, phase_next;
  logic [dtrd_pkg::SPT_W-1:0]     sectors_per_track;
  logic [dtrd_pkg::PACK_W-1:0]    packed_left, packed_left_next;
  logic [TRACK_W-1:0]             track_left, track_left_next;
  logic [dtrd_pkg::DATA_W-1:0]    run_value, run_value_next;
  logic [dtrd_pkg::DATA_W-1:0]    count_high, count_high_next;

  logic [TRACK_W-1:0]             size;
  logic [dtrd_pkg::PACK_W-1:0]    pk_hdr;
  logic [dtrd_pkg::PACK_W-1:0]    pk_dec;
  logic [dtrd_pkg::PACK_W-1:0]    pk_run;
  logic [TRACK_W-1:0]             track_dec;
  logic [dtrd_pkg::REP_W-1:0]     rcnt;
  logic [CMP_W-1:0]               rcnt_ext, tl_ext, cut_ext;
  logic [TRACK_W-1:0]             track_run;
  logic                           is_raw;
  logic                           is_marker;

  assign size      = TRACK_W'(sectors_per_track) * TRACK_W'(SECTOR_BYTES);
  assign pk_hdr    = {packed_left[dtrd_pkg::PACK_W-1:8], a_byte};
  assign pk_dec    = packed_left - dtrd_pkg::PACK_W'(1);
  assign pk_run    = packed_left - dtrd_pkg::PACK_W'(3);
  assign track_dec = track_left - TRACK_W'(1);
  assign rcnt      = {count_high, a_byte};
  assign rcnt_ext  = CMP_W'(rcnt);
  assign tl_ext    = CMP_W'(track_left);
  assign cut_ext   = (rcnt_ext < tl_ext) ? rcnt_ext : tl_ext;
  assign track_run = track_left - TRACK_W'(cut_ext);
  assign is_raw    = (CMP_W'(pk_hdr) == CMP_W'(size));
  assign is_marker = (a_byte == dtrd_pkg::RUN_MARKER);

  // datapath and result
  always_comb begin
    packed_left_next = packed_left;
    track_left_next  = track_left;
    run_value_next   = run_value;
    count_high_next  = count_high;
    res_valid        = 1'b0;
    res              = '0;
    case (phase)
      dtrd_pkg::PH_HDR_HI: begin
        packed_left_next = {a_byte, 8'h00};
      end
      dtrd_pkg::PH_HDR_LO: begin
        packed_left_next = pk_hdr;
        track_left_next  = size;
        if (size == '0) begin
          res_valid     = 1'b1;
          res.track_end = 1'b1;
        end else if (!is_raw && pk_hdr == '0) begin
          res_valid = 1'b1;
          res.error = 1'b1;
        end
      end
      dtrd_pkg::PH_RAW: begin
        track_left_next = track_dec;
        res_valid       = 1'b1;
        res.value       = a_byte;
        res.repeat_res  = dtrd_pkg::REP_W'(1);
        res.track_end   = (track_dec == '0);
      end
      dtrd_pkg::PH_DATA: begin
        packed_left_next = pk_dec;
        if (is_marker) begin
          // marker needs value plus two count bytes behind it
          if (pk_dec < dtrd_pkg::PACK_W'(3)) begin
            res_valid = 1'b1;
            res.error = 1'b1;
          end
        end else begin
          track_left_next = track_dec;
          res_valid       = 1'b1;
          res.value       = a_byte;
          res.repeat_res  = dtrd_pkg::REP_W'(1);
          res.track_end   = (track_dec == '0);
          res.error       = (track_dec != '0) && (pk_dec == '0);
        end
      end
      dtrd_pkg::PH_RUN_VAL: begin
        run_value_next = a_byte;
      end
      dtrd_pkg::PH_CNT_HI: begin
        count_high_next = a_byte;
      end
      dtrd_pkg::PH_CNT_LO: begin
        packed_left_next = pk_run;
        track_left_next  = track_run;
        res_valid        = 1'b1;
        res.value        = run_value;
        res.repeat_res   = dtrd_pkg::REP_W'(cut_ext);
        res.track_end    = (track_run == '0);
        res.error        = (track_run != '0) && (pk_run == '0);
      end
      default: begin
      end
    endcase
  end

  // next phase
  always_comb begin
    case (phase)
      dtrd_pkg::PH_HDR_HI:  phase_next = dtrd_pkg::PH_HDR_LO;
      dtrd_pkg::PH_HDR_LO:  phase_next = is_raw ? dtrd_pkg::PH_RAW : dtrd_pkg::PH_DATA;
      dtrd_pkg::PH_RAW:     phase_next = dtrd_pkg::PH_RAW;
      dtrd_pkg::PH_DATA:    phase_next = is_marker ? dtrd_pkg::PH_RUN_VAL : dtrd_pkg::PH_DATA;
      dtrd_pkg::PH_RUN_VAL: phase_next = dtrd_pkg::PH_CNT_HI;
      dtrd_pkg::PH_CNT_HI:  phase_next = dtrd_pkg::PH_CNT_LO;
      dtrd_pkg::PH_CNT_LO:  phase_next = dtrd_pkg::PH_DATA;
      default:              phase_next = dtrd_pkg::PH_HDR_HI;
    endcase
    // any track end or error goes back to header hunt
    if (res_valid && (res.track_end || res.error)) begin
      phase_next = dtrd_pkg::PH_HDR_HI;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= dtrd_pkg::PH_HDR_HI;
      sectors_per_track <= dtrd_pkg::SPT_RESET;
      packed_left       <= '0;
      track_left        <= '0;
      run_value         <= '0;
      count_high        <= '0;
    end else begin
      if (cfg_wr_en) begin
        sectors_per_track <= cfg_wr_data;
      end
      if (fire) begin
        phase       <= phase_next;
        packed_left <= packed_left_next;
        track_left  <= track_left_next;
        run_value   <= run_value_next;
        count_high  <= count_high_next;
      end
    end
  end

  a_end_not_err: assert property (@(posedge clk) disable iff (rst)
    fire && res_valid && res.track_end |-> !res.error)
    else $error("result flags both track end and error");

  a_back_to_hdr: assert property (@(posedge clk) disable iff (rst)
    fire && res_valid && (res.track_end || res.error) |=> phase == dtrd_pkg::PH_HDR_HI)
    else $error("no return to header after track end or error");

  a_run_result: assert property (@(posedge clk) disable iff (rst)
    fire && phase == dtrd_pkg::PH_CNT_LO |-> res_valid)
    else $error("run count low byte gave no result");

  a_hdr_silent: assert property (@(posedge clk) disable iff (rst)
    phase == dtrd_pkg::PH_HDR_HI |-> !res_valid)
    else $error("header high byte produced a result");

endmodule

### design/dtrd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtrd_out_reg
// Result register; holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module dtrd_out_reg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  dtrd_pkg::res_t              res,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic                        down_busy,
  output logic [dtrd_pkg::DATA_W-1:0] value,
  output logic [dtrd_pkg::REP_W-1:0]  repeat_res,
  output logic                        track_end,
  output logic                        error
);

  dtrd_pkg::res_t held;
  logic           out_valid_next;

  assign down_busy = out_valid & out_stall;

  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign value      = held.value;
  assign repeat_res = held.repeat_res;
  assign track_end  = held.track_end;
  assign error      = held.error;

endmodule

### design/disk_track_rle_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_track_rle_decoder
// Decodes a packed disk-track byte stream into (value, repeat) runs.
// ----------------------------------------------------------------------------
// Input channel: one packed stream byte per transaction (in_valid/in_stall).
// Output channel: one run per transaction: value, repeat_res, track_end, error
// (out_valid/out_stall). Header and run prefix bytes produce no result, except
// an error or, from the header low byte, a track end for a zero track size.
// Config: cfg_wr_en/cfg_wr_data write sectors_per_track; it is used when the
// header low byte is decoded. Write it only while the block is idle.
// Path: input register, then decode into the result register at the outputs.
// Throughput: one byte per cycle unless stalled, set by the single decode step
// between the input register and the result register.
// Stall: while the result register is full and stalled, the held input byte
// waits and in_stall is raised; the block takes no further byte until the
// result leaves.
// Reset (rst, synchronous): both registers empty, sectors_per_track = 9,
// decoder waiting for a track header.
// ----------------------------------------------------------------------------
module disk_track_rle_decoder #(
  parameter int SECTOR_BYTES = dtrd_pkg::SECTOR_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [dtrd_pkg::SPT_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [dtrd_pkg::DATA_W-1:0] data_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dtrd_pkg::DATA_W-1:0] value,
  output logic [dtrd_pkg::REP_W-1:0]  repeat_res,
  output logic                        track_end,
  output logic                        error
);

  logic                        down_busy;
  logic                        a_valid;
  logic [dtrd_pkg::DATA_W-1:0] a_byte;
  logic                        fire;
  logic                        res_valid;
  dtrd_pkg::res_t              res;

  dtrd_in_reg u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .down_busy (down_busy),
    .a_valid   (a_valid),
    .a_byte    (a_byte),
    .fire      (fire)
  );

  dtrd_decode #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_dec (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .a_byte      (a_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  dtrd_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (fire & res_valid),
    .res        (res),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .down_busy  (down_busy),
    .value      (value),
    .repeat_res (repeat_res),
    .track_end  (track_end),
    .error      (error)
  );

  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> a_valid && out_valid)
    else $error("input stalled without a pending byte and full result register");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !(fire && res_valid))
    else $error("stalled result would be overwritten");

  a_fire_valid: assert property (@(posedge clk) disable iff (rst)
    fire |-> a_valid)
    else $error("decode step without a held byte");

endmodule

### tb/tb_disk_track_rle_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_disk_track_rle_decoder
// Self-checking bench for the packed disk-track run-length decoder. Directed
// tracks hit the header corner cases, zero and maximum track sizes and one
// raw track. Random tracks follow: mostly well-formed with random literals,
// runs and counts, mixed with short or long packed lengths and stray bytes.
// A shadow decoder predicts every run. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_disk_track_rle_decoder;

  localparam int SECTOR_BYTES = dtrd_pkg::SECTOR_BYTES_DEF;
  localparam int DRAIN_CYCLES = 6;
  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_ITEMS = 80;

  logic                        clk         = 1'b0;
  logic                        rst         = 1'b1;
  logic                        cfg_wr_en   = 1'b0;
  logic [dtrd_pkg::SPT_W-1:0]  cfg_wr_data = '0;
  logic                        in_valid    = 1'b0;
  logic                        in_stall;
  logic [dtrd_pkg::DATA_W-1:0] data_byte   = '0;
  logic                        out_valid;
  logic                        out_stall   = 1'b0;
  logic [dtrd_pkg::DATA_W-1:0] value;
  logic [dtrd_pkg::REP_W-1:0]  repeat_res;
  logic                        track_end;
  logic                        error;

  logic quiet_tx    = 1'b0;
  logic quiet_rx    = 1'b0;
  int   stall_left  = 0;
  int   idle_cycles = 0;
  int   fail_count  = 0;

  int bytes_sent    = 0;
  int runs_checked  = 0;
  int tracks_done   = 0;
  int error_runs    = 0;
  int settings_used = 0;

  // shadow decoder state
  dtrd_pkg::phase_t           ph         = dtrd_pkg::PH_HDR_HI;
  logic [15:0]                packed_cnt = '0;
  logic [16:0]                track_cnt  = '0;
  logic [7:0]                 run_val    = '0;
  logic [7:0]                 cnt_hi     = '0;
  logic [dtrd_pkg::SPT_W-1:0] spt_cfg    = dtrd_pkg::SPT_RESET;

  dtrd_pkg::res_t pending_runs[$];
  dtrd_pkg::res_t exp_run;

  disk_track_rle_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .value       (value),
    .repeat_res  (repeat_res),
    .track_end   (track_end),
    .error       (error)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic dtrd_pkg::res_t emit_run(input logic [7:0] v, input logic [15:0] rep,
                                              input logic fin, input logic bad);
    dtrd_pkg::res_t r;
    r.value      = v;
    r.repeat_res = rep;
    r.track_end  = fin;
    r.error      = bad;
    if (fin || bad) begin
      ph = dtrd_pkg::PH_HDR_HI;
    end
    return r;
  endfunction

  // Advances the shadow decoder by one stream byte; returns 1 if a run results.
  function automatic bit track_decode(input logic [7:0] b, output dtrd_pkg::res_t r);
    logic [16:0] tsize;
    logic [16:0] rcnt;
    logic [16:0] cut;
    r = '0;
    case (ph)
      dtrd_pkg::PH_HDR_HI: begin
        packed_cnt = {b, 8'h00};
        ph = dtrd_pkg::PH_HDR_LO;
        return 1'b0;
      end
      dtrd_pkg::PH_HDR_LO: begin
        packed_cnt[7:0] = b;
        tsize = 17'(spt_cfg) * 17'(SECTOR_BYTES);
        track_cnt = tsize;
        if (tsize == 0) begin
          r = emit_run(8'h00, 16'h0000, 1'b1, 1'b0);
          return 1'b1;
        end
        if ({1'b0, packed_cnt} == tsize) begin
          ph = dtrd_pkg::PH_RAW;
          return 1'b0;
        end
        if (packed_cnt == 0) begin
          r = emit_run(8'h00, 16'h0000, 1'b0, 1'b1);
          return 1'b1;
        end
        ph = dtrd_pkg::PH_DATA;
        return 1'b0;
      end
      dtrd_pkg::PH_RAW: begin
        track_cnt = track_cnt - 1;
        r = emit_run(b, 16'd1, track_cnt == 0, 1'b0);
        return 1'b1;
      end
      dtrd_pkg::PH_DATA: begin
        packed_cnt = packed_cnt - 1;
        if (b == dtrd_pkg::RUN_MARKER) begin
          // a run needs value and two count bytes still inside the packed length
          if (packed_cnt < 3) begin
            r = emit_run(8'h00, 16'h0000, 1'b0, 1'b1);
            return 1'b1;
          end
          ph = dtrd_pkg::PH_RUN_VAL;
          return 1'b0;
        end
        track_cnt = track_cnt - 1;
        r = emit_run(b, 16'd1, track_cnt == 0, track_cnt != 0 && packed_cnt == 0);
        return 1'b1;
      end
      dtrd_pkg::PH_RUN_VAL: begin
        run_val = b;
        ph = dtrd_pkg::PH_CNT_HI;
        return 1'b0;
      end
      dtrd_pkg::PH_CNT_HI: begin
        cnt_hi = b;
        ph = dtrd_pkg::PH_CNT_LO;
        return 1'b0;
      end
      dtrd_pkg::PH_CNT_LO: begin
        rcnt = {1'b0, cnt_hi, b};
        packed_cnt = packed_cnt - 3;
        cut = (rcnt < track_cnt) ? rcnt : track_cnt;
        track_cnt = track_cnt - cut;
        ph = dtrd_pkg::PH_DATA;
        r = emit_run(run_val, cut[15:0], track_cnt == 0,
                     track_cnt != 0 && packed_cnt == 0);
        return 1'b1;
      end
      default: begin
        ph = dtrd_pkg::PH_HDR_HI;
        return 1'b0;
      end
    endcase
  endfunction

  // Sink side: random stalls, mostly short, a few long.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (quiet_rx || $urandom_range(0, 99) < 60) begin
      out_stall <= 1'b0;
    end else begin
      out_stall  <= 1'b1;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                : $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_runs.size() == 0) begin
        $error("unexpected run: value %0h repeat_res %0d track_end %0b error %0b",
               value, repeat_res, track_end, error);
        fail_count++;
      end else begin
        exp_run = pending_runs.pop_front();
        if (value !== exp_run.value) begin
          $error("value: expected %0h, got %0h", exp_run.value, value);
          fail_count++;
        end
        if (repeat_res !== exp_run.repeat_res) begin
          $error("repeat_res: expected %0d, got %0d", exp_run.repeat_res, repeat_res);
          fail_count++;
        end
        if (track_end !== exp_run.track_end) begin
          $error("track_end: expected %0b, got %0b", exp_run.track_end, track_end);
          fail_count++;
        end
        if (error !== exp_run.error) begin
          $error("error: expected %0b, got %0b", exp_run.error, error);
          fail_count++;
        end
        runs_checked++;
        if (exp_run.track_end) tracks_done++;
        if (exp_run.error) error_runs++;
      end
    end
  end

  // Watchdog: ends the run after too many cycles with no transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int             gap;
    dtrd_pkg::res_t r;
    gap = 0;
    if (!quiet_tx) begin
      gap = $urandom_range(0, 99);
      gap = (gap < 65) ? 0 : (gap < 93) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (track_decode(b, r)) pending_runs.push_back(r);
  endtask

  task automatic send_seq(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Feed bytes until the decoder waits for a header again.
  task automatic resync();
    while (ph != dtrd_pkg::PH_HDR_HI) begin
      case (ph)
        dtrd_pkg::PH_DATA:    send_byte(dtrd_pkg::RUN_MARKER);
        dtrd_pkg::PH_RUN_VAL: send_byte(8'h00);
        dtrd_pkg::PH_CNT_HI,
        dtrd_pkg::PH_CNT_LO:  send_byte(8'hFF);
        default:              send_byte(8'($urandom));
      endcase
    end
  endtask

  // Hold input, let every expected run drain plus the pipeline latency.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_spt(input logic [dtrd_pkg::SPT_W-1:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    spt_cfg = v;
    settings_used++;
  endtask

  task automatic test_header_cases();
    send_seq({8'h00, 8'h00});
    // literals, then a zero-count run that uses up the packed length
    send_seq({8'h00, 8'h06, 8'h00, 8'hFF, dtrd_pkg::RUN_MARKER, 8'hAA, 8'h00, 8'h00});
    send_seq({8'h00, 8'h02, 8'h12, dtrd_pkg::RUN_MARKER});
    send_seq({8'h00, 8'h01, 8'h80});
    // run fills the track early; the leftover bytes become the next header
    send_seq({8'h00, 8'h06, 8'h7F, dtrd_pkg::RUN_MARKER, 8'h5A, 8'hFF, 8'hFF,
              8'h33, 8'h00});
    resync();
  endtask

  task automatic test_zero_track_size();
    write_spt(7'd0);
    send_seq({8'h12, 8'h34, 8'h00, 8'h00});
  endtask

  task automatic test_largest_track();
    write_spt(7'd127);
    send_seq({8'h00, 8'h04, dtrd_pkg::RUN_MARKER, 8'hC3, 8'hFF, 8'hFF});
    send_seq({8'h00, 8'h05, 8'h01, dtrd_pkg::RUN_MARKER, 8'h02, 8'hFE, 8'h00});
  endtask

  task automatic test_raw_track();
    logic [7:0] body[$];
    write_spt(7'd1);
    body.push_back(8'h00);
    body.push_back(8'hFF);
    body.push_back(dtrd_pkg::RUN_MARKER);
    while (body.size() < SECTOR_BYTES) body.push_back(8'($urandom));
    send_seq({8'(SECTOR_BYTES >> 8), 8'(SECTOR_BYTES)});
    send_seq(body);
  endtask

  task automatic test_random_tracks();
    logic [7:0] body[$];
    int         start;
    int         left;
    int         n;
    int         cnt;
    int         plen;
    int         r;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 10 || bytes_sent == start) begin
        r = $urandom_range(0, 9);
        write_spt((r == 0) ? 7'd127 : (r == 1) ? 7'd1
                                      : dtrd_pkg::SPT_W'($urandom_range(1, 12)));
      end
      if ($urandom_range(0, 7) == 0) begin
        quiet_tx <= ($urandom_range(0, 2) == 0);
        quiet_rx <= ($urandom_range(0, 2) == 0);
      end
      if ($urandom_range(0, 14) == 0) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end else begin
        body.delete();
        left = spt_cfg * SECTOR_BYTES;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n && left > 0; i++) begin
          r = $urandom_range(0, 99);
          if (i == n - 1 && r < 75) begin
            // closing run: exact fill or a little over to exercise the cut
            cnt = left + (($urandom_range(0, 1) == 1) ? $urandom_range(0, 200) : 0);
            if (cnt > 65535) cnt = 65535;
            body.push_back(dtrd_pkg::RUN_MARKER);
            body.push_back(8'($urandom));
            body.push_back(8'(cnt >> 8));
            body.push_back(8'(cnt));
            left = 0;
          end else if (r < 55) begin
            body.push_back(8'($urandom));
            left--;
          end else begin
            r = $urandom_range(0, 99);
            cnt = (r < 10) ? 0 : (r < 85) ? $urandom_range(1, 64) : $urandom_range(0, 65535);
            body.push_back(dtrd_pkg::RUN_MARKER);
            body.push_back(8'($urandom));
            body.push_back(8'(cnt >> 8));
            body.push_back(8'(cnt));
            left -= (cnt < left) ? cnt : left;
          end
        end
        plen = body.size();
        r = $urandom_range(0, 99);
        if (r < 8) begin
          plen = plen - $urandom_range(1, 3);
          if (plen < 0) plen = 0;
        end else if (r < 14) begin
          plen = plen + $urandom_range(1, 3);
        end
        send_seq({8'(plen >> 8), 8'(plen)});
        send_seq(body);
      end
      resync();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_header_cases();
    test_zero_track_size();
    test_largest_track();
    test_raw_track();
    test_random_tracks();
    wait_drained();
    $display("Decoded %0d stream bytes into %0d runs: %0d complete tracks, %0d error runs.",
             bytes_sent, runs_checked, tracks_done, error_runs);
    $display("Used %0d track sizes, from zero sectors up to 127, raw and packed tracks.",
             settings_used);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
